// ----- rtl/wia_pkg.sv -----
`timescale 1ns / 1ps

package wia_pkg;

  localparam int unsigned LimbW  = 64;
  localparam int unsigned NLimbs = 4;
  localparam int unsigned WordW  = LimbW * NLimbs;
  localparam int unsigned AmtW   = 9;
  localparam int unsigned CntW   = 9;
  localparam int unsigned CmdW   = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_AND = 4'd0,
    CMD_OR  = 4'd1,
    CMD_XOR = 4'd2,
    CMD_NOT = 4'd3,
    CMD_NEG = 4'd4,
    CMD_SHR = 4'd5,
    CMD_SHL = 4'd6,
    CMD_ADD = 4'd7,
    CMD_CTZ = 4'd8,
    CMD_EQ  = 4'd9
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [AmtW-1:0]  amt;
  } op_t;

  typedef struct packed {
    logic [WordW-1:0] r;
    logic             carry;
    logic [CntW-1:0]  zcnt;
    logic             eq;
  } res_t;

endpackage

// ----- rtl/wia_shift.sv -----
`timescale 1ns / 1ps

module wia_shift (
  input  logic [wia_pkg::WordW-1:0] a_i,
  input  logic [wia_pkg::AmtW-1:0]  amt_i,
  input  logic                      left_i,
  output logic [wia_pkg::WordW-1:0] r_o
);

  logic [wia_pkg::AmtW-2:0]  sh_dist;
  logic [wia_pkg::WordW-1:0] shl;
  logic [wia_pkg::WordW-1:0] shr;

  // low 8 bits give the distance, the top bit means the whole word is shifted out
  assign sh_dist = amt_i[wia_pkg::AmtW-2:0];
  assign shl     = a_i << sh_dist;
  assign shr     = a_i >> sh_dist;

  always_comb begin
    if (amt_i[wia_pkg::AmtW-1]) begin
      r_o = '0;
    end else if (left_i) begin
      r_o = shl;
    end else begin
      r_o = shr;
    end
  end

endmodule

// ----- rtl/wia_ctz.sv -----
`timescale 1ns / 1ps

module wia_ctz (
  input  logic [wia_pkg::WordW-1:0] a_i,
  output logic [wia_pkg::CntW-1:0]  cnt_o
);

  logic [wia_pkg::NLimbs-1:0] nz;
  logic [5:0]                 lcnt [wia_pkg::NLimbs];

  // per-limb priority encoder, lowest set bit wins
  always_comb begin
    for (int l = 0; l < wia_pkg::NLimbs; l++) begin
      nz[l]   = |a_i[l*wia_pkg::LimbW +: wia_pkg::LimbW];
      lcnt[l] = '0;
      for (int i = wia_pkg::LimbW - 1; i >= 0; i--) begin
        if (a_i[l*wia_pkg::LimbW + i]) begin
          lcnt[l] = 6'(i);
        end
      end
    end
  end

  always_comb begin
    priority if (nz[0]) begin
      cnt_o = {3'b000, lcnt[0]};
    end else if (nz[1]) begin
      cnt_o = {3'b001, lcnt[1]};
    end else if (nz[2]) begin
      cnt_o = {3'b010, lcnt[2]};
    end else if (nz[3]) begin
      cnt_o = {3'b011, lcnt[3]};
    end else begin
      cnt_o = 9'd256;
    end
  end

endmodule

// ----- rtl/wia_alu.sv -----
`timescale 1ns / 1ps

module wia_alu (
  input  wia_pkg::op_t  op_i,
  output wia_pkg::res_t res_o
);

  logic [wia_pkg::WordW-1:0] add_x;
  logic [wia_pkg::WordW-1:0] add_y;
  logic [wia_pkg::WordW:0]   sum;
  logic [wia_pkg::WordW-1:0] sh;
  logic [wia_pkg::CntW-1:0]  zcnt;
  logic                      is_neg;

  // negate shares the adder as ~a + 1
  assign is_neg = (op_i.cmd == wia_pkg::CMD_NEG);
  assign add_x  = is_neg ? ~op_i.a : op_i.a;
  assign add_y  = is_neg ? wia_pkg::WordW'(1) : op_i.b;
  assign sum    = {1'b0, add_x} + {1'b0, add_y};

  wia_shift u_shift (
    .a_i    (op_i.a),
    .amt_i  (op_i.amt),
    .left_i (op_i.cmd == wia_pkg::CMD_SHL),
    .r_o    (sh)
  );

  wia_ctz u_ctz (
    .a_i   (op_i.a),
    .cnt_o (zcnt)
  );

  always_comb begin
    res_o = '0;
    unique case (op_i.cmd)
      wia_pkg::CMD_AND: res_o.r = op_i.a & op_i.b;
      wia_pkg::CMD_OR:  res_o.r = op_i.a | op_i.b;
      wia_pkg::CMD_XOR: res_o.r = op_i.a ^ op_i.b;
      wia_pkg::CMD_NOT: res_o.r = ~op_i.a;
      wia_pkg::CMD_NEG: res_o.r = sum[wia_pkg::WordW-1:0];
      wia_pkg::CMD_SHR: res_o.r = sh;
      wia_pkg::CMD_SHL: res_o.r = sh;
      wia_pkg::CMD_ADD: begin
        res_o.r     = sum[wia_pkg::WordW-1:0];
        res_o.carry = sum[wia_pkg::WordW];
      end
      wia_pkg::CMD_CTZ: res_o.zcnt = zcnt;
      wia_pkg::CMD_EQ:  res_o.eq = (op_i.a == op_i.b);
      default: res_o = '0;
    endcase
  end

endmodule

// ----- rtl/wide_integer_alu_256.sv -----
`timescale 1ns / 1ps

// channel   direction  strobe           fields
// command   in         start_i/busy_o   cmd_i, a_limb0..3_i, b_limb0..3_i, shift_amount_i
// result    out        done_o           r_limb0..3_o, carry_out_o, zero_count_o, equal_o
//
// a command transfers when start_i is high and busy_o is low; busy_o is always low
// two-stage pipeline: operand register, then result register after the alu logic
// done_o rises once the command has passed the operand and result registers, the result transfers on the next edge
// one command per cycle sustained; the 256-bit adder and shifter set the clock
// reset clears only the valid flags, the receiver cannot stall the result

module wide_integer_alu_256 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  cmd_i,
  input  logic [63:0] a_limb0_i,
  input  logic [63:0] a_limb1_i,
  input  logic [63:0] a_limb2_i,
  input  logic [63:0] a_limb3_i,
  input  logic [63:0] b_limb0_i,
  input  logic [63:0] b_limb1_i,
  input  logic [63:0] b_limb2_i,
  input  logic [63:0] b_limb3_i,
  input  logic [8:0]  shift_amount_i,
  output logic        done_o,
  output logic [63:0] r_limb0_o,
  output logic [63:0] r_limb1_o,
  output logic [63:0] r_limb2_o,
  output logic [63:0] r_limb3_o,
  output logic        carry_out_o,
  output logic [8:0]  zero_count_o,
  output logic        equal_o
);

  logic          in_valid_q;
  logic          out_valid_q;
  wia_pkg::op_t  op_d;
  wia_pkg::op_t  op_q;
  wia_pkg::res_t res_d;
  wia_pkg::res_t res_q;
  logic          take;

  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  assign op_d.cmd = cmd_i;
  assign op_d.a   = {a_limb3_i, a_limb2_i, a_limb1_i, a_limb0_i};
  assign op_d.b   = {b_limb3_i, b_limb2_i, b_limb1_i, b_limb0_i};
  assign op_d.amt = shift_amount_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= take;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q <= op_d;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  wia_alu u_alu (
    .op_i  (op_q),
    .res_o (res_d)
  );

  assign done_o       = out_valid_q;
  assign r_limb0_o    = res_q.r[63:0];
  assign r_limb1_o    = res_q.r[127:64];
  assign r_limb2_o    = res_q.r[191:128];
  assign r_limb3_o    = res_q.r[255:192];
  assign carry_out_o  = res_q.carry;
  assign zero_count_o = res_q.zcnt;
  assign equal_o      = res_q.eq;

  // every result comes from a command that has passed the operand and result registers
  a_done_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without a command");

  // carry, equality and trailing-zero count belong to different commands
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $countones({carry_out_o, equal_o, |zero_count_o}) <= 1)
    else $error("more than one flag field set");

  a_zcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> zero_count_o <= 9'd256)
    else $error("trailing zero count out of range");

  // equality and count results leave the data limbs clear
  a_eq_limbs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (equal_o || (zero_count_o != 9'd0)) |->
      ((r_limb0_o | r_limb1_o | r_limb2_o | r_limb3_o) == 64'd0))
    else $error("limbs set on a flag result");

endmodule

// ----- test/alu_result_checker.sv -----
`timescale 1ns / 1ps

module alu_result_checker
  import wia_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [3:0]  cmd_i,
  input  logic [63:0] a_limb0_i,
  input  logic [63:0] a_limb1_i,
  input  logic [63:0] a_limb2_i,
  input  logic [63:0] a_limb3_i,
  input  logic [63:0] b_limb0_i,
  input  logic [63:0] b_limb1_i,
  input  logic [63:0] b_limb2_i,
  input  logic [63:0] b_limb3_i,
  input  logic [8:0]  shift_amount_i,
  input  logic        done_i,
  input  logic [63:0] r_limb0_i,
  input  logic [63:0] r_limb1_i,
  input  logic [63:0] r_limb2_i,
  input  logic [63:0] r_limb3_i,
  input  logic        carry_out_i,
  input  logic [8:0]  zero_count_i,
  input  logic        equal_i,
  output int          fail_count_o,
  output int          pending_o
);

  res_t expected_results[$];

  function automatic res_t alu_predict(logic [CmdW-1:0] cmd, logic [WordW-1:0] a,
                                       logic [WordW-1:0] b, logic [AmtW-1:0] amt);
    res_t           res;
    logic [WordW:0] sum;
    int unsigned    tz;
    res = '0;
    case (cmd)
      CMD_AND: res.r = a & b;
      CMD_OR:  res.r = a | b;
      CMD_XOR: res.r = a ^ b;
      CMD_NOT: res.r = ~a;
      CMD_NEG: res.r = ~a + 1'b1;
      CMD_SHR: res.r = (amt >= WordW) ? '0 : a >> amt;
      CMD_SHL: res.r = (amt >= WordW) ? '0 : a << amt;
      CMD_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        res.r = sum[WordW-1:0];
        res.carry = sum[WordW];
      end
      CMD_CTZ: begin
        // all zeros leaves the count at the full width
        tz = WordW;
        for (int i = WordW - 1; i >= 0; i--) begin
          if (a[i]) tz = i;
        end
        res.zcnt = tz[CntW-1:0];
      end
      CMD_EQ:  res.eq = (a == b);
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  initial fail_count_o = 0;

  assign pending_o = expected_results.size();

  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni) begin
      // a result always belongs to an earlier command than the one transferring now, so check before pushing
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command pending");
          fail_count_o++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("r_limb0", exp_res.r[63:0],    r_limb0_i);
          check_field("r_limb1", exp_res.r[127:64],  r_limb1_i);
          check_field("r_limb2", exp_res.r[191:128], r_limb2_i);
          check_field("r_limb3", exp_res.r[255:192], r_limb3_i);
          check_field("carry_out", 64'(exp_res.carry), 64'(carry_out_i));
          check_field("zero_count", 64'(exp_res.zcnt), 64'(zero_count_i));
          check_field("equal", 64'(exp_res.eq), 64'(equal_i));
        end
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(alu_predict(cmd_i,
            {a_limb3_i, a_limb2_i, a_limb1_i, a_limb0_i},
            {b_limb3_i, b_limb2_i, b_limb1_i, b_limb0_i}, shift_amount_i));
      end
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import wia_pkg::*;

  localparam int NumRandom  = 1575;
  localparam int NoIdleTail = 300;
  localparam int StallLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  cmd = '0;
  logic [63:0] a_limb0 = '0, a_limb1 = '0, a_limb2 = '0, a_limb3 = '0;
  logic [63:0] b_limb0 = '0, b_limb1 = '0, b_limb2 = '0, b_limb3 = '0;
  logic [8:0]  shift_amount = '0;
  logic        done;
  logic [63:0] r_limb0, r_limb1, r_limb2, r_limb3;
  logic        carry_out;
  logic [8:0]  zero_count;
  logic        equal;
  int          fail_count;
  int          pending;
  int          stall_cycles = 0;

  wide_integer_alu_256 u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .cmd_i          (cmd),
    .a_limb0_i      (a_limb0),
    .a_limb1_i      (a_limb1),
    .a_limb2_i      (a_limb2),
    .a_limb3_i      (a_limb3),
    .b_limb0_i      (b_limb0),
    .b_limb1_i      (b_limb1),
    .b_limb2_i      (b_limb2),
    .b_limb3_i      (b_limb3),
    .shift_amount_i (shift_amount),
    .done_o         (done),
    .r_limb0_o      (r_limb0),
    .r_limb1_o      (r_limb1),
    .r_limb2_o      (r_limb2),
    .r_limb3_o      (r_limb3),
    .carry_out_o    (carry_out),
    .zero_count_o   (zero_count),
    .equal_o        (equal)
  );

  alu_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .a_limb0_i      (a_limb0),
    .a_limb1_i      (a_limb1),
    .a_limb2_i      (a_limb2),
    .a_limb3_i      (a_limb3),
    .b_limb0_i      (b_limb0),
    .b_limb1_i      (b_limb1),
    .b_limb2_i      (b_limb2),
    .b_limb3_i      (b_limb3),
    .shift_amount_i (shift_amount),
    .done_i         (done),
    .r_limb0_i      (r_limb0),
    .r_limb1_i      (r_limb1),
    .r_limb2_i      (r_limb2),
    .r_limb3_i      (r_limb3),
    .carry_out_i    (carry_out),
    .zero_count_i   (zero_count),
    .equal_i        (equal),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // cycles with neither a command nor a result transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("FAIL wide_integer_alu_256");
        $finish;
      end
    end
  end

  function automatic logic [WordW-1:0] random_word();
    logic [WordW-1:0] w;
    for (int i = 0; i < WordW / 32; i++) w[i*32 +: 32] = $urandom();
    case ($urandom_range(0, 8))
      0: w = '0;
      1: w = '1;
      2: w = {{(WordW-1){1'b0}}, 1'b1} << $urandom_range(0, WordW - 1);
      3: w = ~({{(WordW-1){1'b0}}, 1'b1} << $urandom_range(0, WordW - 1));
      4: begin
        for (int l = 0; l < NLimbs; l++) begin
          case ($urandom_range(0, 2))
            0: w[l*LimbW +: LimbW] = '0;
            1: w[l*LimbW +: LimbW] = '1;
            default: ;
          endcase
        end
      end
      5: w = w & {$urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom(), $urandom()};
      6: w = w << $urandom_range(0, WordW);
      default: ;
    endcase
    return w;
  endfunction

  task automatic issue_op(input logic [3:0] op, input logic [WordW-1:0] a,
                          input logic [WordW-1:0] b, input logic [8:0] amt,
                          input bit allow_idle);
    int gap;
    cmd          <= op;
    a_limb0      <= a[63:0];
    a_limb1      <= a[127:64];
    a_limb2      <= a[191:128];
    a_limb3      <= a[255:192];
    b_limb0      <= b[63:0];
    b_limb1      <= b[127:64];
    b_limb2      <= b[191:128];
    b_limb3      <= b[255:192];
    shift_amount <= amt;
    start        <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [WordW-1:0] ones, one, opa, opb;
    logic [3:0]       op;
    logic [8:0]       amt;
    int               shift_picks[11];
    ones = '1;
    one  = {{(WordW-1){1'b0}}, 1'b1};
    shift_picks = '{0, 63, 64, 65, 127, 128, 191, 192, 255, 256, 511};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    issue_op(CMD_AND, ones, random_word(), 9'($urandom()), 1'b1);
    issue_op(CMD_OR, '0, ones, 9'($urandom()), 1'b1);
    issue_op(CMD_XOR, ones, ones, 9'($urandom()), 1'b1);
    issue_op(CMD_NOT, '0, ones, 9'($urandom()), 1'b1);
    issue_op(CMD_NEG, '0, ones, 9'($urandom()), 1'b1);
    issue_op(CMD_NEG, one, '0, 9'($urandom()), 1'b1);
    issue_op(CMD_SHR, ones, '0, 9'd0, 1'b1);
    issue_op(CMD_SHL, ones, '0, 9'd0, 1'b1);
    issue_op(CMD_SHR, ones, '0, 9'd256, 1'b1);
    issue_op(CMD_SHL, ones, '0, 9'd511, 1'b1);
    issue_op(CMD_SHR, ones, '0, 9'd255, 1'b1);
    issue_op(CMD_SHL, ones, '0, 9'd64, 1'b1);
    issue_op(CMD_ADD, ones, one, 9'($urandom()), 1'b1);
    issue_op(CMD_ADD, ones, ones, 9'($urandom()), 1'b1);
    issue_op(CMD_CTZ, '0, ones, 9'($urandom()), 1'b1);
    issue_op(CMD_CTZ, one << (WordW - 1), '0, 9'($urandom()), 1'b1);
    issue_op(CMD_CTZ, one, ones, 9'($urandom()), 1'b1);
    issue_op(CMD_EQ, ones, ones, 9'($urandom()), 1'b1);
    issue_op(CMD_EQ, ones, ones ^ (one << 200), 9'($urandom()), 1'b1);
    // opcodes past the last defined one
    for (int c = int'(CMD_EQ) + 1; c < 2 ** CmdW; c++) begin
      issue_op(4'(c), ones, ones, 9'h1ff, 1'b1);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if ($urandom_range(0, 19) != 0) op = 4'($urandom_range(0, int'(CMD_EQ)));
      else op = 4'($urandom_range(int'(CMD_EQ) + 1, 2 ** CmdW - 1));
      opa = random_word();
      case ($urandom_range(0, 5))
        0: opb = opa;
        1: opb = ~opa;
        2: opb = ~opa + 256'($urandom_range(0, 3));
        3: opb = opa ^ (one << $urandom_range(0, WordW - 1));
        default: opb = random_word();
      endcase
      case ($urandom_range(0, 4))
        0: amt = 9'(shift_picks[$urandom_range(0, 10)]);
        1: amt = 9'($urandom_range(256, 511));
        default: amt = 9'($urandom_range(0, 255));
      endcase
      // stretches of back-to-back commands, and no idle gaps at all near the end
      issue_op(op, opa, opb, amt,
               (n < NumRandom - NoIdleTail) && ((n / 100) % 3 != 2));
    end
    start <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS wide_integer_alu_256");
    end else begin
      $display("FAIL wide_integer_alu_256");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wia_pkg.sv
rtl/wia_shift.sv
rtl/wia_ctz.sv
rtl/wia_alu.sv
rtl/wide_integer_alu_256.sv
test/alu_result_checker.sv
test/tb_top.sv
